>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the cache lookup design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/slc_pkg.sv
// ----------------------------------------------------------------------------
// slc_pkg
// Types, codes and constants shared by the cache lookup modules.
// ----------------------------------------------------------------------------
`default_nettype none

package slc_pkg;

    localparam int STAMP_W     = 64;
    localparam int COUNT_W     = 32;
    localparam int WAY_IDX_W   = 4;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 104;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_STORE  = 2'd1;
    localparam logic [1:0] OP_MODIFY = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [1:0] CFG_OFFSET_BITS = 2'd1;
    localparam logic [1:0] CFG_WAYS_IN_USE = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SPLIT,
        ST_SCAN,
        ST_UPDATE,
        ST_EMIT
    } t_state;

    // Outcome of a scan over the ways of one set.
    typedef struct packed {
        logic                 hit;
        logic                 evict;
        logic [WAY_IDX_W-1:0] way;
    } t_scan_result;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] value);
        sat_inc = (value == COUNT_MAX) ? value : value + COUNT_W'(1);
    endfunction

endpackage

`default_nettype wire

>>> design/slc_ram.sv
// ----------------------------------------------------------------------------
// slc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module slc_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0] i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // Read data holds until the next read.
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> design/slc_way_scan.sv
// ----------------------------------------------------------------------------
// slc_way_scan
// Shared compare unit: checks one way per step for a tag match, a free
// line and the oldest timestamp, and keeps the running outcome.
// ----------------------------------------------------------------------------
`default_nettype none

module slc_way_scan
    import slc_pkg::*;
#(
    parameter int TAG_W = 64,
    parameter int WAY_W = 3
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire logic               i_first,
    input  wire logic [WAY_W-1:0]   i_way,
    input  wire logic               i_line_valid,
    input  wire logic [TAG_W-1:0]   i_line_tag,
    input  wire logic [STAMP_W-1:0] i_line_stamp,
    input  wire logic [TAG_W-1:0]   i_tag,
    output t_scan_result            o_result
);

    logic               r_hit;
    logic               r_free;
    logic [WAY_W-1:0]   r_hit_way;
    logic [WAY_W-1:0]   r_free_way;
    logic [WAY_W-1:0]   r_lru_way;
    logic [STAMP_W-1:0] r_min_stamp;

    logic hit_prev;
    logic free_prev;
    logic match;
    logic older;

    assign hit_prev  = i_first ? 1'b0 : r_hit;
    assign free_prev = i_first ? 1'b0 : r_free;
    assign match     = i_line_valid && (i_line_tag == i_tag);
    // Strictly older only, so the lowest way wins a tie.
    assign older     = i_first || (i_line_stamp < r_min_stamp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else if (i_step) begin
            r_hit  <= hit_prev || match;
            r_free <= free_prev || !i_line_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            if (!hit_prev && match) begin
                r_hit_way <= i_way;
            end
            if (!free_prev && !i_line_valid) begin
                r_free_way <= i_way;
            end
            if (older) begin
                r_min_stamp <= i_line_stamp;
                r_lru_way   <= i_way;
            end
        end
    end

    always_comb begin
        o_result.hit   = r_hit;
        o_result.evict = !r_hit && !r_free;
        if (r_hit) begin
            o_result.way = WAY_IDX_W'(r_hit_way);
        end else if (r_free) begin
            o_result.way = WAY_IDX_W'(r_free_way);
        end else begin
            o_result.way = WAY_IDX_W'(r_lru_way);
        end
    end

endmodule

`default_nettype wire

>>> design/set_assoc_lru_cache_lookup.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_lookup
// Tag-only set-associative cache lookup with LRU replacement and counters.
// ----------------------------------------------------------------------------
// Each access reads the whole set as one row of the line memory, walks the
// ways in use through a single compare unit one way per cycle, then writes
// the updated row back and presents one result; a modify makes two such
// passes and presents two results, the second marked last. A waiting
// result holds the block in its result step, and the block takes no new
// transaction until it has presented its last result. An unused opcode is
// consumed with no result. After reset the block sweeps the line memory
// clear, one set per cycle, before it takes the first transaction;
// configuration writes are taken throughout.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module set_assoc_lru_cache_lookup
    import slc_pkg::*;
#(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_WIDTH   = 64
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [1:0]             i_cfg_index,
    input  wire logic [4:0]             i_cfg_wdata,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // address [63:0], opcode [65:64], zero [71:66]
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // hit [0], miss [1], eviction [2], hit_total [34:3],
    // miss_total [66:35], eviction_total [98:67], zero [103:99]
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,
    output logic                        o_m_axis_tlast
);

    localparam int ROWS   = 1 << MAX_SET_BITS;
    localparam int ROW_AW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int SB_W   = $clog2(MAX_SET_BITS + 2);
    localparam int SH_W   = 6;
    localparam int LINE_W = 1 + ADDR_WIDTH + STAMP_W;
    localparam int ROW_W  = MAX_WAYS * LINE_W;

    t_state r_state;
    t_state n_state;

    logic [2:0]            r_set_bits;
    logic [4:0]            r_offset_bits;
    logic [3:0]            r_ways_in_use;
    logic [ROW_AW-1:0]     r_clr_idx;
    logic [ADDR_WIDTH-1:0] r_addr;
    logic [1:0]            r_op;
    logic                  r_pass;
    logic [ROW_AW-1:0]     r_set_idx;
    logic [ADDR_WIDTH-1:0] r_tag;
    logic [WAY_W-1:0]      r_way;
    logic [STAMP_W-1:0]    r_next_stamp;
    logic [COUNT_W-1:0]    r_hit_total;
    logic [COUNT_W-1:0]    r_miss_total;
    logic [COUNT_W-1:0]    r_evict_total;
    logic                  r_m_tvalid;
    logic                  r_out_hit;
    logic                  r_out_miss;
    logic                  r_out_evict;
    logic                  r_out_last;
    logic [COUNT_W-1:0]    r_out_hit_total;
    logic [COUNT_W-1:0]    r_out_miss_total;
    logic [COUNT_W-1:0]    r_out_evict_total;

    logic                  s_accept;
    logic                  ram_rd_en;
    logic                  ram_wr_en;
    logic [ROW_AW-1:0]     ram_wr_addr;
    logic [ROW_W-1:0]      ram_wr_data;
    logic [ROW_W-1:0]      ram_rd_data;
    logic [ROW_W-1:0]      upd_row;
    logic                  scan_step;
    logic                  emit;
    logic                  more_pass;

    logic [SB_W-1:0]       sb;
    logic [SH_W-1:0]       tag_shift;
    logic [ADDR_WIDTH-1:0] set_shifted;
    logic [ROW_AW-1:0]     split_set;
    logic [ADDR_WIDTH-1:0] split_tag;
    logic [WAY_W-1:0]      last_way;
    logic [WAY_W-1:0]      tgt_way;
    logic [LINE_W-1:0]     cur_line;
    t_scan_result          scan_res;

    // ------------------------------------------------------------------
    // Address split and effective configuration
    // ------------------------------------------------------------------
    always_comb begin
        if (int'(r_set_bits) > MAX_SET_BITS) begin
            sb = SB_W'(MAX_SET_BITS);
        end else begin
            sb = SB_W'(r_set_bits);
        end
        if (r_ways_in_use == 4'd0) begin
            last_way = '0;
        end else if (int'(r_ways_in_use) > MAX_WAYS) begin
            last_way = WAY_W'(MAX_WAYS - 1);
        end else begin
            last_way = WAY_W'(r_ways_in_use - 4'd1);
        end
    end

    assign tag_shift   = SH_W'(sb) + SH_W'(r_offset_bits);
    assign set_shifted = r_addr >> r_offset_bits;
    assign split_set   = set_shifted[ROW_AW-1:0] & ~({ROW_AW{1'b1}} << sb);
    assign split_tag   = r_addr >> tag_shift;

    // ------------------------------------------------------------------
    // Line memory: one row per set, way w in bits [w*LINE_W +: LINE_W],
    // each line laid out as {stamp, tag, valid}.
    // ------------------------------------------------------------------
    slc_ram #(
        .DATA_W (ROW_W),
        .DEPTH  (ROWS),
        .ADDR_W (ROW_AW)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (split_set),
        .o_rd_data (ram_rd_data)
    );

    assign cur_line = ram_rd_data[r_way*LINE_W +: LINE_W];

    slc_way_scan #(
        .TAG_W (ADDR_WIDTH),
        .WAY_W (WAY_W)
    ) u_way_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (scan_step),
        .i_first      (r_way == '0),
        .i_way        (r_way),
        .i_line_valid (cur_line[0]),
        .i_line_tag   (cur_line[ADDR_WIDTH:1]),
        .i_line_stamp (cur_line[LINE_W-1 -: STAMP_W]),
        .i_tag        (r_tag),
        .o_result     (scan_res)
    );

    assign tgt_way = scan_res.way[WAY_W-1:0];

    always_comb begin
        upd_row = ram_rd_data;
        upd_row[tgt_way*LINE_W +: LINE_W] = {r_next_stamp, r_tag, 1'b1};
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign more_pass = (r_op == OP_MODIFY) && !r_pass;
    assign s_accept  = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        ram_rd_en       = 1'b0;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = r_set_idx;
        ram_wr_data     = upd_row;
        scan_step       = 1'b0;
        emit            = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_clr_idx;
                ram_wr_data = '0;
                if (r_clr_idx == ROW_AW'(ROWS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid && (i_s_axis_tdata[65:64] != OP_NONE)) begin
                    n_state = ST_SPLIT;
                end
            end
            ST_SPLIT: begin
                ram_rd_en = 1'b1;
                n_state   = ST_SCAN;
            end
            ST_SCAN: begin
                scan_step = 1'b1;
                if (r_way == last_way) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                ram_wr_en = 1'b1;
                n_state   = ST_EMIT;
            end
            ST_EMIT: begin
                if (!r_m_tvalid || i_m_axis_tready) begin
                    emit    = 1'b1;
                    n_state = more_pass ? ST_SPLIT : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers, counters and configuration
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits    <= 3'd4;
            r_offset_bits <= 5'd4;
            r_ways_in_use <= 4'd1;
            r_clr_idx     <= '0;
            r_pass        <= 1'b0;
            r_way         <= '0;
            r_next_stamp  <= STAMP_W'(1);
            r_hit_total   <= '0;
            r_miss_total  <= '0;
            r_evict_total <= '0;
            r_m_tvalid    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_SET_BITS:    r_set_bits    <= i_cfg_wdata[2:0];
                    CFG_OFFSET_BITS: r_offset_bits <= i_cfg_wdata[4:0];
                    CFG_WAYS_IN_USE: r_ways_in_use <= i_cfg_wdata[3:0];
                    default:         ;
                endcase
            end
            if (r_state == ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + ROW_AW'(1);
            end
            if (s_accept) begin
                r_pass <= 1'b0;
            end
            if (r_state == ST_SPLIT) begin
                r_way <= '0;
            end
            if (scan_step) begin
                r_way <= r_way + WAY_W'(1);
            end
            if (r_state == ST_UPDATE) begin
                r_next_stamp <= r_next_stamp + STAMP_W'(1);
                if (scan_res.hit) begin
                    r_hit_total <= sat_inc(r_hit_total);
                end else begin
                    r_miss_total <= sat_inc(r_miss_total);
                end
                if (scan_res.evict) begin
                    r_evict_total <= sat_inc(r_evict_total);
                end
            end
            if (emit) begin
                r_m_tvalid <= 1'b1;
                r_pass     <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_addr <= i_s_axis_tdata[ADDR_WIDTH-1:0];
            r_op   <= i_s_axis_tdata[65:64];
        end
        if (r_state == ST_SPLIT) begin
            r_set_idx <= split_set;
            r_tag     <= split_tag;
        end
        if (emit) begin
            r_out_hit         <= scan_res.hit;
            r_out_miss        <= !scan_res.hit;
            r_out_evict       <= scan_res.evict;
            r_out_last        <= !more_pass;
            r_out_hit_total   <= r_hit_total;
            r_out_miss_total  <= r_miss_total;
            r_out_evict_total <= r_evict_total;
        end
    end

    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {5'd0, r_out_evict_total, r_out_miss_total, r_out_hit_total,
                              r_out_evict, r_out_miss, r_out_hit};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SLC_ASSERT_SAME(a_no_accept_in_clear, i_clk, i_rst_n,
        r_state == ST_CLEAR, !o_s_axis_tready,
        "transaction accepted during the clearing sweep")

    `SLC_ASSERT_NEXT(a_stamp_advances, i_clk, i_rst_n,
        (r_state == ST_UPDATE) && i_rst_n,
        r_next_stamp == $past(r_next_stamp) + STAMP_W'(1),
        "timestamp did not advance by one on a line update")

    `SLC_ASSERT_NEXT(a_miss_total_quiet, i_clk, i_rst_n,
        (r_state != ST_UPDATE) && i_rst_n,
        $stable(r_miss_total) && $stable(r_hit_total),
        "running totals changed outside a line update")

endmodule

`default_nettype wire
